// File: hdl/assert_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/pcmp_pkg.sv
`timescale 1ns / 1ps

package pcmp_pkg;

	localparam int unsigned PRECISION_DEF = 16;
	localparam int unsigned ADDR_BITS_DEF = 16;

	// register map
	typedef enum logic [1:0] {
		REG_PHASE_STEP   = 2'd0,
		REG_DATA_BYTES   = 2'd1,
		REG_WIDE_SAMPLES = 2'd2,
		REG_STEREO       = 2'd3
	} pcmp_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_FETCH = 1'b1
	} pcmp_op_t;

	typedef struct packed {
		pcmp_op_t    operation;
		logic [15:0] byte_address;
		logic [7:0]  byte_value;
	} pcmp_in_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic               is_mono;
		logic               error;
	} pcmp_out_t;

	typedef struct packed {
		pcmp_reg_t   index;
		logic [31:0] value;
	} pcmp_cfg_t;

endpackage

// File: hdl/pcmp_chan_if.sv
`timescale 1ns / 1ps

interface pcmp_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/pcm_ram_phase_accumulator_player_top.sv
`timescale 1ns / 1ps
// A fetch word passes s1 (memory access), s2 (read data) and the output register.
// Throughput: one word per cycle, writes and fetches alike, unless sample_out stalls.
// The sample memory is one 32-bit-wide single-port RAM; a frame never spans two words.
// Reset (arst_n low): phase 0, phase_step 0, data_bytes 0, 16-bit mono, pipe empty.
// Sample memory is not cleared; it reads undefined until written.
`include "assert_macros.svh"

module pcm_ram_phase_accumulator_player_top #(
	parameter int unsigned PRECISION = pcmp_pkg::PRECISION_DEF,
	parameter int unsigned ADDR_BITS = pcmp_pkg::ADDR_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	pcmp_chan_if.sink    sample_in,
	pcmp_chan_if.source  sample_out,
	pcmp_chan_if.sink    cfg
);
	import pcmp_pkg::*;

	// byte memory is organized as 4-byte words; one word holds a whole aligned frame
	localparam int unsigned WORD_BITS = ADDR_BITS - 2;
	localparam int unsigned WORDS     = 1 << WORD_BITS;

	// ---------------------------------------------------------------
	// Configuration registers. A write lands on every cfg handshake;
	// the pipe is expected to be idle when one arrives.
	// ---------------------------------------------------------------
	logic signed [31:0] step_q;
	logic [16:0]        data_bytes_q;
	logic               wide_q;
	logic               stereo_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			data_bytes_q <= '0;
			wide_q       <= 1'b1;
			stereo_q     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_PHASE_STEP:   step_q       <= signed'(cfg.data.value);
				REG_DATA_BYTES:   data_bytes_q <= cfg.data.value[16:0];
				REG_WIDE_SAMPLES: wide_q       <= cfg.data.value[0];
				REG_STEREO:       stereo_q     <= cfg.data.value[0];
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Pipeline handshake. s1: memory access, s2: read data, then out reg.
	// Writes retire in s1; only fetches travel on to s2.
	// ---------------------------------------------------------------
	logic       valid_s1, write_s1, err_s1, wide_s1, stereo_s1;
	logic [WORD_BITS-1:0] widx_s1;
	logic [1:0] off_s1;
	logic [7:0] byte_s1;

	logic        valid_s2, err_s2, wide_s2, stereo_s2;
	logic [1:0]  off_s2;
	logic [31:0] rd_s2;

	logic      out_valid_q;
	pcmp_out_t out_q;

	logic out_free, s2_free, s1_go, s2_go, in_go, fetch_in;

	assign out_free = !out_valid_q || sample_out.ready;
	assign s2_go    = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_go    = valid_s1 && (write_s1 || s2_free);

	assign sample_in.ready = !valid_s1 || s1_go;
	assign in_go           = sample_in.valid && sample_in.ready;
	assign fetch_in        = sample_in.data.operation == OP_FETCH;

	// ---------------------------------------------------------------
	// Phase accumulator: step, then wrap once by M = limit << PRECISION.
	// The three candidate sums are formed side by side, then selected.
	// ---------------------------------------------------------------
	logic [31:0]        phase_q;
	logic [2:0]         frame;
	logic               too_short;
	logic [16:0]        limit;
	logic signed [34:0] modulus, sum, sum_sub, sum_add, wrapped;
	logic [31:0]        new_phase, seek;
	logic               out_of_range;
	logic [1:0]         seek_off;

	always_comb begin
		unique case ({wide_q, stereo_q})
			2'b00:   frame = 3'd1;
			2'b01:   frame = 3'd2;
			2'b10:   frame = 3'd2;
			2'b11:   frame = 3'd4;
			default: frame = 3'd1;
		endcase
	end

	assign too_short = data_bytes_q <= 17'(frame);
	assign limit     = data_bytes_q - 17'(frame);
	assign modulus   = signed'(35'(limit) << PRECISION);
	assign sum       = signed'({3'b000, phase_q}) + 35'(step_q);
	assign sum_sub   = sum - modulus;
	assign sum_add   = sum + modulus;

	always_comb begin
		priority if (sum >= modulus) begin
			wrapped = sum_sub;
		end else if (sum < 35'sd0) begin
			wrapped = sum_add;
		end else begin
			wrapped = sum;
		end
	end

	assign new_phase    = wrapped[31:0];
	assign seek         = new_phase >> PRECISION;
	assign out_of_range = seek >= 32'(limit);
	// frame alignment: frame-1 is the mask of bits to clear (4 wraps to 0)
	assign seek_off     = seek[1:0] & ~(frame[1:0] - 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (in_go && fetch_in && !too_short) begin
			phase_q <= new_phase;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1 capture
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_go) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			write_s1  <= !fetch_in;
			err_s1    <= too_short || out_of_range;
			wide_s1   <= wide_q;
			stereo_s1 <= stereo_q;
			byte_s1   <= sample_in.data.byte_value;
			if (fetch_in) begin
				widx_s1 <= seek[ADDR_BITS-1:2];
				off_s1  <= seek_off;
			end else begin
				widx_s1 <= sample_in.data.byte_address[ADDR_BITS-1:2];
				off_s1  <= sample_in.data.byte_address[1:0];
			end
		end
	end

	// ---------------------------------------------------------------
	// Sample memory: one port, byte-lane write or word read per cycle.
	// A fetch behind a write to the same word reads after the write.
	// ---------------------------------------------------------------
	logic [31:0] sample_mem [0:WORDS-1];

	always_ff @(posedge clk) begin
		if (s1_go) begin
			if (write_s1) begin
				sample_mem[widx_s1][{off_s1, 3'b000} +: 8] <= byte_s1;
			end else begin
				rd_s2 <= sample_mem[widx_s1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: read data waiting for the output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go && !write_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_go) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && !write_s1) begin
			err_s2    <= err_s1;
			wide_s2   <= wide_s1;
			stereo_s2 <= stereo_s1;
			off_s2    <= off_s1;
		end
	end

	// sample formatting: align the frame to bit 0, then pick channels
	logic [31:0] frame_bits;
	pcmp_out_t   result;

	assign frame_bits = rd_s2 >> {off_s2, 3'b000};

	always_comb begin
		result = '0;
		if (err_s2) begin
			result.error = 1'b1;
		end else begin
			result.is_mono = !stereo_s2;
			if (wide_s2) begin
				result.left_sample = signed'(frame_bits[15:0]);
				if (stereo_s2) begin
					result.right_sample = signed'(frame_bits[31:16]);
				end
			end else begin
				// unsigned 8-bit: flip the top bit to recenter, scale by 256
				result.left_sample = signed'({~frame_bits[7], frame_bits[6:0], 8'h00});
				if (stereo_s2) begin
					result.right_sample = signed'({~frame_bits[15], frame_bits[14:8], 8'h00});
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= 1'b1;
		end else if (sample_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			out_q <= result;
		end
	end

	assign sample_out.valid = out_valid_q;
	assign sample_out.data  = out_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// error words carry no sample content
	logic out_blank;

	assign out_blank = out_q.left_sample == 16'sd0 && out_q.right_sample == 16'sd0 &&
		!out_q.is_mono;

	`ASSERT_NEXT(a_short_keeps_phase, clk, arst_n, in_go && fetch_in && too_short, $stable(phase_q))
	`ASSERT_NEXT(a_stall_holds_read, clk, arst_n, valid_s2 && !s2_go, $stable(rd_s2))
	`ASSERT_IMPLY(a_error_is_blank, clk, arst_n, out_valid_q && out_q.error, out_blank)

endmodule
